// ===== sv/boot_frame_receiver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Boot frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef BOOT_FRAME_RECEIVER_CORE_MACROS_SVH
`define BOOT_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication.
`define BFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Boot frame receiver package
// Status codes, result item type and shared widths.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TYPE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CSUM  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_end;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   payload_count;
    } result_t;

    // Frame engine to result buffer
    typedef struct packed {
        logic    push;
        result_t item;
    } result_push_t;

endpackage

// ===== sv/bfr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// Boot frame receiver frame engine
// Frame state and per-byte update; one byte per advance.
// ----------------------------------------------------------------------------
`include "boot_frame_receiver_core_macros.svh"

module bfr_frame_fsm
    import bfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [BYTE_W-1:0] expected_type,
    output result_push_t      res
);

    logic              in_frame_reg,     in_frame_next;
    logic [BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0] byte_index_reg,   byte_index_next;
    logic [BYTE_W-1:0] running_xor_reg,  running_xor_next;
    logic              type_matched_reg, type_matched_next;

    logic [BYTE_W-1:0] idx_inc;
    logic [BYTE_W-1:0] xor_upd;
    logic              tm_upd;

    assign idx_inc = byte_index_reg + BYTE_W'(1);
    assign xor_upd = running_xor_reg ^ byte_in;
    assign tm_upd  = (idx_inc == BYTE_W'(1)) ? (byte_in == expected_type) : type_matched_reg;

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        running_xor_next  = running_xor_reg;
        type_matched_next = type_matched_reg;
        res               = '0;

        if (advance)
        begin
            if (!in_frame_reg)
            begin
                if (byte_in == '0)
                begin
                    res.push        = 1'b1;
                    res.item.frame_end = 1'b1;
                    res.item.status = STATUS_EMPTY;
                end
                else
                begin
                    in_frame_next     = 1'b1;
                    frame_length_next = byte_in;
                    byte_index_next   = '0;
                    running_xor_next  = byte_in;
                    type_matched_next = 1'b0;
                end
            end
            else
            begin
                byte_index_next   = idx_inc;
                running_xor_next  = xor_upd;
                type_matched_next = tm_upd;
                if (idx_inc >= frame_length_reg)
                begin
                    // checksum byte: close the frame
                    in_frame_next      = 1'b0;
                    res.push           = 1'b1;
                    res.item.frame_end = 1'b1;
                    res.item.payload_count = (frame_length_reg >= BYTE_W'(2))
                                           ? frame_length_reg - BYTE_W'(2) : '0;
                    priority if (!tm_upd)
                        res.item.status = STATUS_TYPE;
                    else if (xor_upd != '0)
                        res.item.status = STATUS_CSUM;
                    else
                        res.item.status = STATUS_OK;
                end
                else if (idx_inc >= BYTE_W'(2))
                begin
                    res.push           = 1'b1;
                    res.item.data_byte = byte_in;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            frame_length_reg <= '0;
            byte_index_reg   <= '0;
            running_xor_reg  <= '0;
            type_matched_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
            running_xor_reg  <= running_xor_next;
            type_matched_reg <= type_matched_next;
        end
    end

    `BFR_ASSERT_NOW(a_idx_below_len, in_frame_reg, byte_index_reg < frame_length_reg,
        "byte index reached frame length inside a frame")
    `BFR_ASSERT_NOW(a_close_with_end, advance && in_frame_reg && !in_frame_next,
        res.push && res.item.frame_end, "frame closed without an end item")
    `BFR_ASSERT_NEXT(a_open_clean, advance && !in_frame_reg && in_frame_next,
        byte_index_reg == '0 && running_xor_reg == frame_length_reg,
        "frame opened with stale index or checksum")

endmodule

// ===== sv/bfr_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Boot frame receiver result buffer
// Two-entry queue between the frame engine and the result channel.
// ----------------------------------------------------------------------------
`include "boot_frame_receiver_core_macros.svh"

module bfr_result_fifo
    import bfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_push_t wr,
    output logic         full,
    output logic         res_valid,
    input  logic         res_stall,
    output result_t      head
);

    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign pop       = res_valid && !res_stall;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr.push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem_reg[wr_ptr_reg] <= wr.item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BFR_ASSERT_NOW(a_no_overflow, wr.push, !full, "push into a full result buffer")
    `BFR_ASSERT_NOW(a_count_range, 1'b1, count_reg <= 2'd2, "result count out of range")
    `BFR_ASSERT_NEXT(a_ptr_gap, 1'b1,
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg),
        "pointers disagree with count")

endmodule

// ===== sv/boot_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// Boot frame receiver core - length-prefixed, XOR-checked frame receiver
// A result item passes the input register and the result buffer before
// it is offered; a full buffer can hold it back.
// Throughput: 1 byte per cycle while the result buffer has room.
// Reset (rst_n, async low): frame state idle, buffers empty, expected_type 0.
// ----------------------------------------------------------------------------
module boot_frame_receiver_core
    import bfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // received byte channel
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,

    // expected message type register
    input  logic              expected_type_we,
    input  logic [BYTE_W-1:0] expected_type_wdata,

    // result channel
    output logic                res_valid,
    input  logic                res_stall,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                frame_end,
    output logic [STATUS_W-1:0] status,
    output logic [BYTE_W-1:0]   payload_count
);

    // Pipeline:
    //   rx item -> input register -> frame engine (XOR, index, compare)
    //           -> two-entry result buffer -> result channel.
    // The engine consumes the staged byte whenever the buffer has room,
    // whether or not that byte yields a result item (length and type
    // bytes give none unless they end a frame). A stalled result side fills
    // the buffer; only then does rx_stall rise, driven from registers alone.

    logic              expected_type_reg;
    logic [BYTE_W-1:0] expected_type_q_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              advance;
    logic              buf_full;
    logic              rx_take;
    result_push_t      eng_res;
    result_t           head;

    // Configuration register. The user must write it only while idle, so no
    // ordering against bytes still in flight is needed; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_type_reg   <= 1'b0;
            expected_type_q_reg <= '0;
        end
        else if (expected_type_we)
        begin
            expected_type_reg   <= 1'b1;
            expected_type_q_reg <= expected_type_wdata;
        end
    end

    // Input register: holds a byte until the engine can take it.
    assign advance  = s1_valid_reg && !buf_full;
    assign rx_stall = s1_valid_reg && buf_full;
    assign rx_take  = rx_valid && !rx_stall;

    always_comb
    begin
        s1_valid_next = rx_take || (s1_valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            s1_byte_reg <= rx_byte;
    end

    // Frame engine: one state update per consumed byte.
    bfr_frame_fsm u_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .byte_in       (s1_byte_reg),
        .expected_type (expected_type_reg ? expected_type_q_reg : '0),
        .res           (eng_res)
    );

    // Result buffer: lets the next byte in while a result waits.
    bfr_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (eng_res),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    assign data_byte     = head.data_byte;
    assign frame_end     = head.frame_end;
    assign status        = head.status;
    assign payload_count = head.payload_count;

endmodule

// ===== verif/boot_frame_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// Boot frame receiver core testbench
// Drives length-prefixed frames into the receiver and checks every payload
// and end-of-frame item against a cycle-free predictor of the frame logic.
// ----------------------------------------------------------------------------
module boot_frame_receiver_core_tb;
    import bfr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    // leave a margin after the last result item before a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int PHASE_ITEMS   = 400;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 200;

    // DUT ports, all inputs start at known values
    logic                clk                 = 1'b0;
    logic                rst_n               = 1'b0;
    logic                rx_valid            = 1'b0;
    logic                rx_stall;
    logic [BYTE_W-1:0]   rx_byte             = '0;
    logic                expected_type_we    = 1'b0;
    logic [BYTE_W-1:0]   expected_type_wdata = '0;
    logic                res_valid;
    logic                res_stall           = 1'b0;
    logic [BYTE_W-1:0]   data_byte;
    logic                frame_end;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   payload_count;

    // bytes waiting to be offered, and result items the frame logic owes us
    logic [BYTE_W-1:0] tx_bytes_q[$];
    result_t           results_due_q[$];
    logic [BYTE_W-1:0] frame_buf[$];

    // predictor state, mirrors the frame engine
    logic [BYTE_W-1:0] type_shadow = '0;
    logic              fr_active   = 1'b0;
    logic [BYTE_W-1:0] fr_length   = '0;
    logic [BYTE_W-1:0] fr_index    = '0;
    logic [BYTE_W-1:0] fr_xor      = '0;
    logic              fr_type_ok  = 1'b0;

    int cyc             = 0;
    int fail_count      = 0;
    int items_queued    = 0;
    int frames_ended    = 0;
    int results_checked = 0;
    int cfg_writes      = 0;

    boot_frame_receiver_core dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx_valid            (rx_valid),
        .rx_stall            (rx_stall),
        .rx_byte             (rx_byte),
        .expected_type_we    (expected_type_we),
        .expected_type_wdata (expected_type_wdata),
        .res_valid           (res_valid),
        .res_stall           (res_stall),
        .data_byte           (data_byte),
        .frame_end           (frame_end),
        .status              (status),
        .payload_count       (payload_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // Random idling, except in a quiet window that recurs at the end of each period of cyc
    function automatic bit draw_idle();
        if ((cyc % 2500) >= 2000)
            return 1'b0;
        return ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Advance the frame predictor by one accepted byte.
    // Length byte opens a frame (0 = empty frame, ends at once), byte 1 is the
    // type, bytes 2..L-1 are payload, byte L closes with the status.
    task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        if (!fr_active)
        begin
            if (b == '0)
            begin
                r.frame_end = 1'b1;
                r.status    = STATUS_EMPTY;
                results_due_q.push_back(r);
                frames_ended++;
            end
            else
            begin
                fr_active  = 1'b1;
                fr_length  = b;
                fr_index   = '0;
                fr_xor     = b;
                fr_type_ok = 1'b0;
            end
        end
        else
        begin
            fr_index = fr_index + 8'd1;
            fr_xor   = fr_xor ^ b;
            // type compared against the register value at the time it arrives
            if (fr_index == 8'd1)
                fr_type_ok = (b == type_shadow);
            if (fr_index >= fr_length)
            begin
                r.frame_end     = 1'b1;
                r.payload_count = (fr_length >= 8'd2) ? fr_length - 8'd2 : 8'd0;
                // type mismatch wins over a bad checksum
                if (!fr_type_ok)
                    r.status = STATUS_TYPE;
                else if (fr_xor != '0)
                    r.status = STATUS_CSUM;
                else
                    r.status = STATUS_OK;
                fr_active = 1'b0;
                results_due_q.push_back(r);
                frames_ended++;
            end
            else if (fr_index >= 8'd2)
            begin
                r.data_byte = b;
                results_due_q.push_back(r);
            end
        end
    endtask

    // Driver: predict on acceptance, then offer the next byte or idle.
    // A stalled byte stays put with valid held high.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && !rx_stall)
            begin
                track_rx_byte(rx_byte);
                void'(tx_bytes_q.pop_front());
            end
            if (!(rx_valid && rx_stall))
            begin
                if (tx_bytes_q.size() != 0 && !draw_idle())
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= tx_bytes_q[0];
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check accepted result items, drive res_stall.
    // Long hold-offs are counted here so the block backs up into rx_stall.
    int mon_cycles = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int next_hold  = 600;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_checked++;
                if (results_due_q.size() == 0)
                begin
                    $error("unexpected result item: data_byte %0h frame_end %0b status %0d count %0d",
                           data_byte, frame_end, status, payload_count);
                    fail_count++;
                end
                else
                begin
                    want = results_due_q.pop_front();
                    if (data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
                        fail_count++;
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (payload_count !== want.payload_count)
                    begin
                        $error("payload_count: expected %0d, got %0d",
                               want.payload_count, payload_count);
                        fail_count++;
                    end
                end
            end

            mon_cycles++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (holds_done < 2 && mon_cycles >= next_hold && rx_valid)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                next_hold = mon_cycles + 2500;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= draw_idle();
            end
        end
    end

    // Timeout
    initial
    begin : watchdog
        wait (cyc >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d result items still due",
                 cyc, results_due_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        tx_bytes_q.push_back(b);
        items_queued++;
    endtask

    task automatic send_frame_from(input int start);
        int i;
        for (i = start; i < frame_buf.size(); i++)
            send_byte(frame_buf[i]);
    endtask

    // Build one frame in frame_buf; checksum closes the XOR unless bad_csum.
    // A length-one frame carries a single byte that is type and checksum at once.
    task automatic build_frame(input int len, input logic [BYTE_W-1:0] type_byte,
                               input bit bad_csum);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] b;
        int i;
        frame_buf.delete();
        frame_buf.push_back(len[7:0]);
        if (len == 0)
            return;
        frame_buf.push_back(type_byte);
        if (len == 1)
            return;
        x = len[7:0] ^ type_byte;
        for (i = 2; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            frame_buf.push_back(b);
            x = x ^ b;
        end
        if (bad_csum)
            x = x ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(x);
    endtask

    // Wait until every byte is taken and every owed item has come back
    task automatic wait_idle();
        while (tx_bytes_q.size() != 0 || rx_valid || results_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_expected_type(input logic [BYTE_W-1:0] v);
        @(posedge clk);
        expected_type_we    <= 1'b1;
        expected_type_wdata <= v;
        @(posedge clk);
        expected_type_we    <= 1'b0;
        type_shadow = v;
        cfg_writes++;
        @(negedge clk);
    endtask

    // Stimulus
    initial
    begin : stimulus
        int target;
        int phase_end;
        int phase_idx;
        int k;
        int len;
        int n;
        logic [BYTE_W-1:0] next_type;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames, expected_type still at its reset value 0
        send_byte(8'h00);                                   // empty frame
        send_byte(8'h01); send_byte(8'h00);                 // length one, checksum off
        send_byte(8'h03); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFC);
        // wrong type and wrong checksum: type is reported
        send_byte(8'h03); send_byte(8'h5A); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h02); send_byte(8'h00); send_byte(8'h02); // no payload
        send_byte(8'h04); send_byte(8'h00); send_byte(8'h80); send_byte(8'h01);
        send_byte(8'h84);                                   // checksum off by one bit
        // register changes between the length byte and the type byte
        send_byte(8'h03);
        wait_idle();
        write_expected_type(8'hFF);
        send_byte(8'hFF); send_byte(8'h7E); send_byte(8'h85);
        wait_idle();
        // length one that passes both checks
        write_expected_type(8'h01);
        send_byte(8'h01); send_byte(8'h01);

        // Random part: mostly well-formed frames, some broken, a little noise
        target    = items_queued + RANDOM_ITEMS;
        build_frame(255, type_shadow, 1'b0);
        send_frame_from(0);
        phase_idx = 0;
        while (items_queued < target)
        begin
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end && items_queued < target)
            begin
                k   = $urandom_range(99);
                len = ($urandom_range(49) == 0) ? $urandom_range(13, 255)
                                                : $urandom_range(1, 10);
                if (k < 62)
                begin
                    build_frame(len, type_shadow, 1'b0);
                    send_frame_from(0);
                end
                else if (k < 74)
                begin
                    build_frame(len, type_shadow ^ 8'($urandom_range(1, 255)),
                                bit'($urandom_range(1)));
                    send_frame_from(0);
                end
                else if (k < 86)
                begin
                    build_frame(len, type_shadow, 1'b1);
                    send_frame_from(0);
                end
                else if (k < 93)
                begin
                    send_byte(8'h00);
                end
                else
                begin
                    // raw bytes, knock the framing out of step
                    n = $urandom_range(1, 3);
                    repeat (n) send_byte(8'($urandom_range(255)));
                end
            end

            // new register setting; the extremes come round every third phase
            case (phase_idx % 3)
                0:       next_type = 8'h00;
                1:       next_type = 8'hFF;
                default: next_type = 8'($urandom_range(255));
            endcase
            phase_idx++;
            if ($urandom_range(1) == 1)
            begin
                // write lands between a frame's length byte and its type byte
                build_frame($urandom_range(2, 8), next_type, 1'b0);
                send_byte(frame_buf[0]);
                wait_idle();
                write_expected_type(next_type);
                send_frame_from(1);
            end
            else
            begin
                wait_idle();
                write_expected_type(next_type);
            end
        end

        wait_idle();
        $display("sent %0d bytes, %0d frames ended, %0d result items checked, %0d register writes",
                 items_queued, frames_ended, results_checked, cfg_writes);
        $display("covered empty/length-one frames, type and checksum errors, %0d hold-offs",
                 holds_done);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bfr_pkg.sv
sv/bfr_frame_fsm.sv
sv/bfr_result_fifo.sv
sv/boot_frame_receiver_core.sv
verif/boot_frame_receiver_core_tb.sv
